>>> design/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

  // Defaults for the top-level parameters
  localparam int DefCapacity  = 2048;
  localparam int DefMaxBlocks = 64;

  // Fixed field widths of the request and result
  localparam int KindW     = 2;
  localparam int OwnerW    = 8;
  localparam int SizeW     = 12;
  localparam int StatusW   = 3;
  localparam int AddrOutW  = 11;
  localparam int UsageW    = 7;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 24;

  // Usage is reported in percent
  localparam int UsageScale = 100;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 3'd0,
    ST_RESIDENT = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

endpackage

>>> design/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps

// First-fit block allocator.
// Requests arrive on the s_axis channel: tuser carries the kind (allocate,
// free, lookup), tdata the owner id and the requested size. Each request
// yields exactly one result on the m_axis channel: tuser carries the status,
// tdata the block start address and the usage in percent.
// The block table lives in a ring of MAX_BLOCKS cells that rotates one entry
// per cycle past the controller while it searches or rewrites. A request
// takes one full rotation to search plus a decision state; allocate and free
// that change the table take a second rotation that rewrites it in place. The
// usage divider starts at the decision and its figure is ready before that
// second rotation ends. The time from a request's transfer to a valid result
// is limited by the rotation of the ring.
// One request is in work at a time: s_axis_tready is high only while idle.
// The result is held on m_axis until it is taken; a stalled receiver holds
// the block with it. After reset the table holds one free block covering the
// whole capacity and no clearing pass is needed.
module first_fit_block_allocator_core #(
  parameter int CAPACITY   = ffa_pkg::DefCapacity,
  parameter int MAX_BLOCKS = ffa_pkg::DefMaxBlocks
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // owner [7:0], size [19:8], zero [23:20]
  input  logic [ffa_pkg::InDataW-1:0]     s_axis_tdata,
  // kind [1:0]
  input  logic [ffa_pkg::KindW-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // address [10:0], usage_percent [17:11], zero [23:18]
  output logic [ffa_pkg::OutDataW-1:0]    m_axis_tdata,
  // status [2:0]
  output logic [ffa_pkg::StatusW-1:0]     m_axis_tuser
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int OW   = ffa_pkg::OwnerW;
  localparam int SW   = ffa_pkg::SizeW;
  localparam int EW   = 1 + OW + AW + LW;
  localparam int PW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (LW > SW) ? LW : SW;
  localparam int AOW  = ffa_pkg::AddrOutW;
  localparam int UGW  = ffa_pkg::UsageW;

  localparam logic [EW-1:0] RstFirst = {1'b0, {OW{1'b0}}, {AW{1'b0}}, LW'(CAPACITY)};

  // Controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // Rewrite operations of the second rotation
  localparam logic [1:0] OP_EXACT = 2'd0;
  localparam logic [1:0] OP_SPLIT = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  function automatic logic [LW-1:0] f_len(input logic [EW-1:0] e);
    return e[LW-1:0];
  endfunction

  function automatic logic [AW-1:0] f_start(input logic [EW-1:0] e);
    return e[LW+AW-1:LW];
  endfunction

  function automatic logic [OW-1:0] f_owner(input logic [EW-1:0] e);
    return e[LW+AW+OW-1:LW+AW];
  endfunction

  function automatic logic f_used(input logic [EW-1:0] e);
    return e[EW-1];
  endfunction

  function automatic logic [EW-1:0] f_pack(input logic used, input logic [OW-1:0] owner,
                                            input logic [AW-1:0] start,
                                            input logic [LW-1:0] len);
    return {used, owner, start, len};
  endfunction

  logic [2:0]    state_q;
  logic [PW-1:0] p_q;
  logic [1:0]    kind_q;
  logic [OW-1:0] owner_q;
  logic [SW-1:0] size_q;
  logic [CW-1:0] count_q;
  logic [LW-1:0] used_q;
  logic          found_q, jf_q, pf_q, nf_q, fit_q;
  logic [PW-1:0] j_q, fi_q;
  logic [AW-1:0] addrj_q, fitstart_q, addr_q;
  logic [LW-1:0] lenj_q, lenn_q, fitlen_q;
  logic [EW-1:0] prev_q;
  logic [1:0]    op_q;
  logic [ffa_pkg::StatusW-1:0] status_q;

  logic [EW-1:0] cell_out [MAX_BLOCKS];
  logic [EW-1:0] c0, c1, c2, tail;
  logic          shift;
  logic          p_last;
  logic [CW-1:0] pe;
  logic          p_valid;
  logic          hit_owner, hit_fit;

  logic [ffa_pkg::StatusW-1:0] dec_status;
  logic [AW-1:0] dec_addr;
  logic          dec_mod;
  logic [1:0]    dec_op;
  logic [LW-1:0] used_d;
  logic          div_start, div_busy;
  logic [UGW-1:0] usage;
  logic [EW-1:0] mod_out;

  // Ring of cells; the controller feeds the last one
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic [EW-1:0] din;
    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign din = tail;
    end else begin : g_link
      assign din = cell_out[k+1];
    end
    ffa_cell #(
      .W       (EW),
      .RST_VAL ((k == 0) ? RstFirst : {EW{1'b0}})
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .din_i   (din),
      .dout_o  (cell_out[k])
    );
  end

  assign c0 = cell_out[0];
  assign c1 = cell_out[1];
  if (MAX_BLOCKS > 2) begin : g_look2
    assign c2 = cell_out[2];
  end else begin : g_nolook2
    assign c2 = '0;
  end

  assign shift   = (state_q == S_SCAN) || (state_q == S_MOD);
  assign tail    = (state_q == S_SCAN) ? c0 : mod_out;
  assign p_last  = p_q == PW'(MAX_BLOCKS - 1);
  assign pe      = CW'(p_q);
  assign p_valid = pe < count_q;

  // Search hits on the entry at the head of the ring
  assign hit_owner = p_valid && f_used(c0) && (f_owner(c0) == owner_q) && !found_q;
  assign hit_fit   = p_valid && !f_used(c0) && (CMPW'(f_len(c0)) >= CMPW'(size_q)) && !fit_q;

  // Decide the outcome once the search rotation is complete
  always_comb begin
    dec_status = ffa_pkg::ST_NOTFOUND;
    dec_addr   = '0;
    dec_mod    = 1'b0;
    dec_op     = OP_EXACT;
    used_d     = used_q;
    case (kind_q)
      ffa_pkg::KIND_ALLOC: begin
        if (found_q) begin
          dec_status = ffa_pkg::ST_RESIDENT;
          dec_addr   = addrj_q;
        end else if ((size_q == '0) || !fit_q) begin
          dec_status = ffa_pkg::ST_NOFIT;
        end else if (CMPW'(fitlen_q) == CMPW'(size_q)) begin
          dec_status = ffa_pkg::ST_DONE;
          dec_addr   = fitstart_q;
          dec_mod    = 1'b1;
          dec_op     = OP_EXACT;
          used_d     = used_q + LW'(size_q);
        end else if (count_q >= CW'(MAX_BLOCKS)) begin
          dec_status = ffa_pkg::ST_FULL;
        end else begin
          dec_status = ffa_pkg::ST_DONE;
          dec_addr   = fitstart_q;
          dec_mod    = 1'b1;
          dec_op     = OP_SPLIT;
          used_d     = used_q + LW'(size_q);
        end
      end
      ffa_pkg::KIND_FREE: begin
        if (found_q) begin
          dec_status = ffa_pkg::ST_DONE;
          dec_addr   = addrj_q;
          dec_mod    = 1'b1;
          dec_op     = OP_FREE;
          used_d     = used_q - lenj_q;
        end
      end
      ffa_pkg::KIND_LOOKUP: begin
        if (found_q) begin
          dec_status = ffa_pkg::ST_DONE;
          dec_addr   = addrj_q;
        end
      end
      default: begin
        dec_status = ffa_pkg::ST_NOTFOUND;
      end
    endcase
  end

  // Rewrite the entry stream during the second rotation
  always_comb begin
    logic [CW-1:0] fi_e, j_e, tgt;
    logic [1:0]    del;
    logic [CW:0]   reach;
    logic [EW-1:0] src;
    logic [LW-1:0] merged;
    fi_e    = CW'(fi_q);
    j_e     = CW'(j_q);
    tgt     = pf_q ? (j_e - 1'b1) : j_e;
    del     = {1'b0, pf_q} + {1'b0, nf_q};
    reach   = {1'b0, pe} + (CW+1)'(del);
    src     = (del == 2'd2) ? c2 : ((del == 2'd1) ? c1 : c0);
    merged  = f_len(c0) + (pf_q ? lenj_q : '0) + (nf_q ? lenn_q : '0);
    mod_out = c0;
    case (op_q)
      OP_EXACT: begin
        if (pe == fi_e) begin
          mod_out = f_pack(1'b1, owner_q, f_start(c0), f_len(c0));
        end
      end
      OP_SPLIT: begin
        if (pe == fi_e) begin
          mod_out = f_pack(1'b1, owner_q, f_start(c0), LW'(size_q));
        end else if (pe == fi_e + 1'b1) begin
          mod_out = f_pack(1'b0, '0, f_start(prev_q) + AW'(size_q),
                           f_len(prev_q) - LW'(size_q));
        end else if (pe > fi_e) begin
          mod_out = (pe <= count_q) ? prev_q : '0;
        end
      end
      OP_FREE: begin
        if (pe == tgt) begin
          mod_out = f_pack(1'b0, f_owner(c0), f_start(c0), merged);
        end else if (pe > tgt) begin
          mod_out = (reach < (CW+1)'(count_q)) ? src : '0;
        end
      end
      default: begin
        mod_out = c0;
      end
    endcase
  end

  assign div_start = state_q == S_DECIDE;

  ffa_usage_div #(
    .CAPACITY (CAPACITY),
    .UW       (LW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .used_i  (used_d),
    .busy_o  (div_busy),
    .usage_o (usage)
  );

  // Sequence one request: search, decide, rewrite, wait for usage, deliver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      p_q        <= '0;
      kind_q     <= '0;
      owner_q    <= '0;
      size_q     <= '0;
      count_q    <= CW'(1);
      used_q     <= '0;
      found_q    <= 1'b0;
      jf_q       <= 1'b0;
      pf_q       <= 1'b0;
      nf_q       <= 1'b0;
      fit_q      <= 1'b0;
      j_q        <= '0;
      fi_q       <= '0;
      addrj_q    <= '0;
      fitstart_q <= '0;
      addr_q     <= '0;
      lenj_q     <= '0;
      lenn_q     <= '0;
      fitlen_q   <= '0;
      prev_q     <= '0;
      op_q       <= OP_EXACT;
      status_q   <= ffa_pkg::ST_NOTFOUND;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind_q  <= s_axis_tuser;
            owner_q <= s_axis_tdata[OW-1:0];
            size_q  <= s_axis_tdata[OW+SW-1:OW];
            found_q <= 1'b0;
            jf_q    <= 1'b0;
            pf_q    <= 1'b0;
            nf_q    <= 1'b0;
            fit_q   <= 1'b0;
            p_q     <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          prev_q <= c0;
          p_q    <= p_last ? '0 : p_q + 1'b1;
          jf_q   <= hit_owner;
          if (hit_owner) begin
            found_q <= 1'b1;
            j_q     <= p_q;
            addrj_q <= f_start(c0);
            lenj_q  <= f_len(c0);
            pf_q    <= (p_q != '0) && !f_used(prev_q);
          end
          // Note the neighbor right after the owner's block
          if (jf_q) begin
            nf_q   <= p_valid && !f_used(c0);
            lenn_q <= f_len(c0);
          end
          if (hit_fit) begin
            fit_q      <= 1'b1;
            fi_q       <= p_q;
            fitlen_q   <= f_len(c0);
            fitstart_q <= f_start(c0);
          end
          if (p_last) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          status_q <= dec_status;
          addr_q   <= dec_addr;
          op_q     <= dec_op;
          used_q   <= used_d;
          state_q  <= dec_mod ? S_MOD : S_WAIT;
        end
        S_MOD: begin
          prev_q <= c0;
          p_q    <= p_last ? '0 : p_q + 1'b1;
          if (p_last) begin
            if (op_q == OP_SPLIT) begin
              count_q <= count_q + 1'b1;
            end else if (op_q == OP_FREE) begin
              count_q <= count_q - CW'({1'b0, pf_q} + {1'b0, nf_q});
            end
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!div_busy) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = state_q == S_OUT;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {{(ffa_pkg::OutDataW - AOW - UGW){1'b0}}, usage, AOW'(addr_q)};

  // The table always holds between one and MAX_BLOCKS entries
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(1)) && (count_q <= CW'(MAX_BLOCKS)))
    else $error("block count out of range");

  // A delivered result carries a finished usage figure
  a_usage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !div_busy)
    else $error("result shown while usage divider busy");

  // The ring position is aligned whenever no request is in work
  a_ring_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (p_q == '0))
    else $error("ring misaligned at idle");

  // A refused split only happens with a full table
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status_q == ffa_pkg::ST_FULL)) |-> (count_q == CW'(MAX_BLOCKS)))
    else $error("table-full status without a full table");

  // Allocated units never exceed the capacity
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= LW'(CAPACITY))
    else $error("used total exceeds capacity");

endmodule

>>> design/ffa_cell.sv
`timescale 1ns / 1ps

// One table entry of the rotating chain: take the neighbor's entry on each shift.
module ffa_cell #(
  parameter int             W       = 1,
  parameter logic [W-1:0]   RST_VAL = '0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         shift_i,
  input  logic [W-1:0] din_i,
  output logic [W-1:0] dout_o
);

  logic [W-1:0] entry_q;

  // Hold, or advance one place along the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= RST_VAL;
    end else if (shift_i) begin
      entry_q <= din_i;
    end
  end

  assign dout_o = entry_q;

endmodule

>>> design/ffa_usage_div.sv
`timescale 1ns / 1ps

// Usage figure: ceil(used * 100 / CAPACITY) by reciprocal multiplication.
// The rounded-up numerator is registered first; it is then multiplied by
// the scaled reciprocal of CAPACITY and the quotient bits are registered.
module ffa_usage_div #(
  parameter int CAPACITY = ffa_pkg::DefCapacity,
  parameter int UW       = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [UW-1:0]               used_i,
  output logic                        busy_o,
  output logic [ffa_pkg::UsageW-1:0]  usage_o
);

  localparam int     NumW   = $clog2(CAPACITY * (ffa_pkg::UsageScale + 1) + 1);
  localparam int     QW     = ffa_pkg::UsageW;
  // Numerators stay below NumLim; with 2**Shift >= NumLim * CAPACITY the
  // rounded-up reciprocal gives the exact quotient for every one of them
  localparam longint NumLim = longint'(CAPACITY) * longint'(ffa_pkg::UsageScale + 1);
  localparam int     Shift  = $clog2(NumLim * longint'(CAPACITY));
  localparam longint Recip  = ((longint'(1) << Shift) + longint'(CAPACITY) - 1) /
                              longint'(CAPACITY);
  // The quotient never exceeds 100, so the product fits in Shift + QW bits
  localparam int     ProdW  = Shift + QW;

  logic [NumW-1:0]  num_q;
  logic [QW-1:0]    quo_q;
  logic             busy_q;
  logic [ProdW-1:0] prod;

  // Scale by the reciprocal; the quotient sits above the shift point
  assign prod = ProdW'(num_q) * ProdW'(Recip);

  // Load the rounded-up numerator, then take the quotient in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      quo_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      num_q  <= NumW'(used_i) * NumW'(ffa_pkg::UsageScale) + NumW'(CAPACITY - 1);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      quo_q  <= prod[ProdW-1:Shift];
      busy_q <= 1'b0;
    end
  end

  assign busy_o  = busy_q;
  assign usage_o = quo_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int Capacity  = 2048;
  localparam int MaxBlocks = 64;
  localparam int RandItems = 1540;
  localparam int IdleLimit = 20000;

  // Kind value outside the defined set
  localparam logic [ffa_pkg::KindW-1:0] KindUnused = 2'd3;

  // Directed row flag: expected result typed in by hand
  localparam bit Typed = 1'b1;
  localparam bit Pred  = 1'b0;

  typedef struct packed {
    logic [ffa_pkg::KindW-1:0]  kind;
    logic [ffa_pkg::OwnerW-1:0] owner;
    logic [ffa_pkg::SizeW-1:0]  size;
  } request_t;

  typedef struct packed {
    logic [ffa_pkg::StatusW-1:0]  status;
    logic [ffa_pkg::AddrOutW-1:0] addr;
    logic [ffa_pkg::UsageW-1:0]   usage;
  } answer_t;

  typedef struct {
    request_t req;
    bit       typed;
    answer_t  ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ffa_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic [ffa_pkg::KindW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ffa_pkg::OutDataW-1:0] m_axis_tdata;
  logic [ffa_pkg::StatusW-1:0] m_axis_tuser;

  first_fit_block_allocator_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  // Shadow block table
  int unsigned blk_start [MaxBlocks];
  int unsigned blk_len   [MaxBlocks];
  bit          blk_used  [MaxBlocks];
  int unsigned blk_owner [MaxBlocks];
  int unsigned blk_count;
  int unsigned units_taken;

  answer_t pending_answers[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic int find_holder(int unsigned who);
    for (int i = 0; i < blk_count; i++)
      if (blk_used[i] && blk_owner[i] == who) return i;
    return -1;
  endfunction

  // Remove entry idx, shift the tail down
  function automatic void remove_entry(int unsigned idx);
    for (int i = idx; i + 1 < blk_count; i++) begin
      blk_start[i] = blk_start[i+1];
      blk_len[i]   = blk_len[i+1];
      blk_used[i]  = blk_used[i+1];
      blk_owner[i] = blk_owner[i+1];
    end
    blk_count--;
  endfunction

  function automatic answer_t allocate_step(request_t r);
    answer_t a;
    int h;
    int i;
    a.status = ffa_pkg::ST_NOTFOUND;
    a.addr = '0;
    h = find_holder(32'(r.owner));
    if (r.kind == ffa_pkg::KIND_ALLOC) begin
      if (h >= 0) begin
        a.status = ffa_pkg::ST_RESIDENT;
        a.addr = 11'(blk_start[h]);
      end else begin
        a.status = ffa_pkg::ST_NOFIT;
        if (r.size != 0) begin
          for (i = 0; i < blk_count; i++)
            if (!blk_used[i] && blk_len[i] >= r.size) break;
          if (i < blk_count) begin
            if (blk_len[i] == r.size) begin
              a.status = ffa_pkg::ST_DONE;
            end else if (blk_count >= MaxBlocks) begin
              a.status = ffa_pkg::ST_FULL;
            end else begin
              // Open a slot after i for the remainder
              for (int j = blk_count; j > i + 1; j--) begin
                blk_start[j] = blk_start[j-1];
                blk_len[j]   = blk_len[j-1];
                blk_used[j]  = blk_used[j-1];
                blk_owner[j] = blk_owner[j-1];
              end
              blk_count++;
              blk_start[i+1] = blk_start[i] + 32'(r.size);
              blk_len[i+1]   = blk_len[i] - 32'(r.size);
              blk_used[i+1]  = 1'b0;
              blk_owner[i+1] = 0;
              blk_len[i]     = 32'(r.size);
              a.status = ffa_pkg::ST_DONE;
            end
            if (a.status == ffa_pkg::ST_DONE) begin
              blk_used[i] = 1'b1;
              blk_owner[i] = 32'(r.owner);
              units_taken += 32'(r.size);
              a.addr = 11'(blk_start[i]);
            end
          end
        end
      end
    end else if (r.kind == ffa_pkg::KIND_FREE) begin
      if (h >= 0) begin
        a.status = ffa_pkg::ST_DONE;
        a.addr = 11'(blk_start[h]);
        units_taken -= blk_len[h];
        blk_used[h] = 1'b0;
        if (h + 1 < blk_count && !blk_used[h+1]) begin
          blk_len[h] += blk_len[h+1];
          remove_entry(h + 1);
        end
        if (h > 0 && !blk_used[h-1]) begin
          blk_len[h-1] += blk_len[h];
          remove_entry(h);
        end
      end
    end else if (r.kind == ffa_pkg::KIND_LOOKUP) begin
      if (h >= 0) begin
        a.status = ffa_pkg::ST_DONE;
        a.addr = 11'(blk_start[h]);
      end
    end
    a.usage = 7'((units_taken * ffa_pkg::UsageScale + Capacity - 1) / Capacity);
    return a;
  endfunction

  // Drive one request and queue its expected answer at acceptance
  task automatic send_request(request_t r, bit typed, answer_t ans);
    answer_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {4'b0, r.size, r.owner};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = allocate_step(r);
    if (typed && p != ans)
      $display("%0t: typed row disagrees with prediction %h vs %h", $time, ans, p);
    pending_answers.push_back(typed ? ans : p);
  endtask

  // Receiver stalls and comparison
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles <= 0;
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%h", $time, m_axis_tuser,
                   m_axis_tdata);
          errors++;
        end else begin
          e = pending_answers.pop_front();
          if (m_axis_tuser !== e.status || m_axis_tdata[10:0] !== e.addr ||
              m_axis_tdata[17:11] !== e.usage || m_axis_tdata[23:18] !== '0) begin
            $display("%0t: expected st=%0d addr=%0d use=%0d, got st=%0d addr=%0d use=%0d",
                     $time, e.status, e.addr, e.usage, m_axis_tuser,
                     m_axis_tdata[10:0], m_axis_tdata[17:11]);
            errors++;
          end
        end
      end else if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (quiet_cycles >= IdleLimit) begin
      $display("[first_fit_block_allocator_core] ERROR");
      $finish;
    end
  end

  function automatic row_t mk(logic [1:0] k, int o, int s, bit typed,
                              int st = 0, int ad = 0, int us = 0);
    row_t r;
    r.req.kind = k;
    r.req.owner = 8'(o);
    r.req.size = 12'(s);
    r.typed = typed;
    r.ans.status = 3'(st);
    r.ans.addr = 11'(ad);
    r.ans.usage = 7'(us);
    return r;
  endfunction

  function automatic request_t random_request(int owners);
    request_t r;
    int p;
    p = $urandom_range(99);
    r.owner = 8'($urandom_range(owners - 1));
    if (owners > 200) r.owner = 8'($urandom);
    if (p < 50) r.kind = ffa_pkg::KIND_ALLOC;
    else if (p < 82) r.kind = ffa_pkg::KIND_FREE;
    else if (p < 97) r.kind = ffa_pkg::KIND_LOOKUP;
    else r.kind = KindUnused;
    // Mostly small sizes so the table fills up and splits run out
    case ($urandom_range(9))
      0: r.size = 12'($urandom);
      1: r.size = 12'($urandom_range(2048, 1));
      2: r.size = '0;
      default: r.size = 12'($urandom_range(48, 1));
    endcase
    return r;
  endfunction

  row_t    rows[$];
  answer_t none;

  initial begin
    int k;
    none = '0;
    blk_count = 1;
    units_taken = 0;
    foreach (blk_len[i]) begin
      blk_start[i] = 0;
      blk_len[i] = 0;
      blk_used[i] = 0;
      blk_owner[i] = 0;
    end
    blk_len[0] = Capacity;

    // Directed rows
    rows.push_back(mk(ffa_pkg::KIND_LOOKUP, 0, 0, Typed, ffa_pkg::ST_NOTFOUND, 0, 0));
    rows.push_back(mk(ffa_pkg::KIND_FREE, 255, 0, Typed, ffa_pkg::ST_NOTFOUND, 0, 0));
    rows.push_back(mk(KindUnused, 7, 5, Typed, ffa_pkg::ST_NOTFOUND, 0, 0));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 1, 0, Typed, ffa_pkg::ST_NOFIT, 0, 0));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 1, 4095, Typed, ffa_pkg::ST_NOFIT, 0, 0));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 2, 2048, Typed, ffa_pkg::ST_DONE, 0, 100));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 2, 1, Typed, ffa_pkg::ST_RESIDENT, 0, 100));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 3, 1, Typed, ffa_pkg::ST_NOFIT, 0, 100));
    rows.push_back(mk(ffa_pkg::KIND_FREE, 2, 0, Typed, ffa_pkg::ST_DONE, 0, 0));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 255, 1, Typed, ffa_pkg::ST_DONE, 0, 1));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 0, 100, Pred));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 10, 200, Pred));
    rows.push_back(mk(ffa_pkg::KIND_LOOKUP, 0, 0, Pred));
    rows.push_back(mk(ffa_pkg::KIND_FREE, 0, 0, Pred));
    rows.push_back(mk(ffa_pkg::KIND_ALLOC, 11, 50, Pred));
    rows.push_back(mk(ffa_pkg::KIND_FREE, 255, 0, Pred));
    rows.push_back(mk(ffa_pkg::KIND_FREE, 10, 0, Pred));
    rows.push_back(mk(ffa_pkg::KIND_FREE, 11, 0, Pred));
    rows.push_back(mk(ffa_pkg::KIND_LOOKUP, 11, 2730, Pred));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].ans);

    // Fill the table with tiny blocks to hit the full-table refusal
    for (int o = 100; o < 170; o++) begin
      send_request('{kind: ffa_pkg::KIND_ALLOC, owner: o[7:0], size: 12'd1}, Pred, none);
    end
    send_request('{kind: ffa_pkg::KIND_ALLOC, owner: 8'd99, size: 12'd5}, Pred, none);
    // Exact fit into a freed hole still succeeds on a full table
    send_request('{kind: ffa_pkg::KIND_FREE, owner: 8'd120, size: 12'hFFF}, Pred, none);
    send_request('{kind: ffa_pkg::KIND_ALLOC, owner: 8'd98, size: 12'd1}, Pred, none);
    for (int o = 98; o < 170; o++) begin
      send_request('{kind: ffa_pkg::KIND_FREE, owner: o[7:0], size: 12'd0}, Pred, none);
    end

    // Random phases under different idle settings
    k = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3: begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (RandItems / 5) begin
        send_request(random_request((k % 400 < 300) ? 80 : 256), Pred, none);
        k++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("[first_fit_block_allocator_core] OK");
    end else begin
      $display("[first_fit_block_allocator_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/ffa_pkg.sv
design/ffa_cell.sv
design/ffa_usage_div.sv
design/first_fit_block_allocator_core.sv
tb/testbench.sv
